>>> rtl/core/spfs_pkg.sv
// Shared types, constants and register codes of the servo pulse frame sequencer.
package spfs_pkg;

    localparam int MAX_CHANNELS     = 8;
    localparam int DEF_NUM_CHANNELS = 8;
    localparam int POS_W            = 12;
    localparam int SLOT_W           = 4;
    localparam int TICK_W           = 16;
    localparam int PIN_W            = 8;
    localparam int SCALE_W          = 16;
    localparam int APB_DW           = 32;
    localparam int APB_AW           = 3;

    // raw / 1.846 in 16-bit fixed point.
    localparam logic [SCALE_W-1:0] SCALE_MUL   = 16'd35503;
    localparam logic [TICK_W-1:0]  FRAME_RESET = 16'd16250;
    localparam logic [SLOT_W-1:0]  SLOT_RESET  = 4'd9;

    localparam logic [MAX_CHANNELS-1:0][POS_W-1:0] POS_INIT = {
        12'd1000, 12'd1000, 12'd1000, 12'd1000,
        12'd1500, 12'd1000, 12'd1500, 12'd1500
    };

    localparam logic OP_PERIOD  = 1'b0;
    localparam logic OP_CHANNEL = 1'b1;

    localparam logic MODE_PARALLEL = 1'b0;
    localparam logic MODE_COMBINED = 1'b1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_FRAME = 1'b1;

    typedef struct packed {
        logic                              op;
        logic [MAX_CHANNELS-1:0][POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PIN_W-1:0]  pins;
        logic [TICK_W-1:0] period;
    } t_result;

    typedef struct packed {
        logic mode;
        logic [TICK_W-1:0] frame_ticks;
    } t_cfg;

endpackage

>>> rtl/core/spfs_queue.sv
// Two-entry queue used between front and back and at the result side.
module spfs_queue
    import spfs_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [1:0]       r_cnt, n_cnt;
    logic [WIDTH-1:0] r_head, n_head;
    logic [WIDTH-1:0] r_tail, n_tail;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_head;
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        case ({push_ok, pop_ok})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_head = i_data;
                end else begin
                    n_tail = i_data;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_head = r_tail;
                n_cnt  = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_head = i_data;
                end else begin
                    n_head = r_tail;
                    n_tail = i_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

>>> rtl/core/spfs_front.sv
// Front end: classifies an item and unpacks and scales its channel values.
module spfs_front
    import spfs_pkg::*;
(
    input  logic        i_op,
    input  logic [31:0] i_low_bytes_first,
    input  logic [15:0] i_high_nibbles_first,
    input  logic [31:0] i_low_bytes_second,
    input  logic [15:0] i_high_nibbles_second,
    output t_cmd        o_cmd
);

    logic [MAX_CHANNELS-1:0][POS_W-1:0] raw;
    logic [POS_W+SCALE_W-1:0]           prod [MAX_CHANNELS];

    // Two nibble bytes per group of four channels; an odd channel takes the high nibble.
    always_comb begin
        logic [31:0] lows;
        logic [15:0] nibs;
        logic [7:0]  nb;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            lows = (k < 4) ? i_low_bytes_first : i_low_bytes_second;
            nibs = (k < 4) ? i_high_nibbles_first : i_high_nibbles_second;
            nb   = nibs[8*((k%4)/2) +: 8];
            raw[k] = {((k % 2) == 1) ? nb[7:4] : nb[3:0], lows[8*(k%4) +: 8]};
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            prod[k]     = {{SCALE_W{1'b0}}, raw[k]} * {{POS_W{1'b0}}, SCALE_MUL};
            o_cmd.pos[k] = prod[k][POS_W+SCALE_W-1:SCALE_W];
        end
        o_cmd.op = i_op;
    end

endmodule

>>> rtl/core/spfs_back.sv
// Back end: keeps servo positions and steps the frame slot sequence.
module spfs_back
    import spfs_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam logic [SLOT_W-1:0] NCH = SLOT_W'(NUM_CHANNELS);

    logic [MAX_CHANNELS-1:0][POS_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0]                  r_slot, n_slot;
    logic [TICK_W-1:0]                  r_elapsed, n_elapsed;

    logic              is_chan;
    logic [SLOT_W-1:0] slot_inc;
    logic              wrap;
    logic              filler;
    logic [POS_W-1:0]  pos_sel;

    assign is_chan    = (i_cmd.op == OP_CHANNEL);
    assign o_cmd_pop  = !i_cmd_empty && (is_chan || !i_res_full);
    assign o_res_push = !i_cmd_empty && !is_chan && !i_res_full;

    assign slot_inc = r_slot + SLOT_W'(1);
    assign wrap     = (slot_inc > NCH);
    assign n_slot   = wrap ? '0 : slot_inc;
    assign filler   = (n_slot >= NCH);
    assign pos_sel  = r_pos[n_slot[2:0]];

    always_comb begin
        o_res.slot   = n_slot;
        o_res.period = filler ? (i_cfg.frame_ticks - r_elapsed)
                              : {{(TICK_W-POS_W){1'b0}}, pos_sel};
        if (filler || (i_cfg.mode == MODE_COMBINED && n_slot < SLOT_W'(4))) begin
            o_res.pins = '0;
        end else begin
            o_res.pins = PIN_W'(1) << n_slot[2:0];
        end
        // The filler pads the frame, so the running sum lands on the frame length.
        if (wrap) begin
            n_elapsed = {{(TICK_W-POS_W){1'b0}}, pos_sel};
        end else if (filler) begin
            n_elapsed = i_cfg.frame_ticks;
        end else begin
            n_elapsed = r_elapsed + {{(TICK_W-POS_W){1'b0}}, pos_sel};
        end
    end

    always_comb begin
        n_pos = r_pos;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (k < NUM_CHANNELS) begin
                n_pos[k] = i_cmd.pos[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_INIT;
            r_slot    <= SLOT_RESET;
            r_elapsed <= '0;
        end else begin
            if (o_cmd_pop && is_chan) begin
                r_pos <= n_pos;
            end
            if (o_res_push) begin
                r_slot    <= n_slot;
                r_elapsed <= n_elapsed;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot <= NCH) || (r_slot == SLOT_RESET))
    else $error("slot counter left the frame range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> $onehot0(o_res.pins))
    else $error("more than one servo pin raised");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && filler) |=> (r_elapsed == $past(i_cfg.frame_ticks)))
    else $error("elapsed sum does not match frame length after filler");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && is_chan) |-> !o_res_push)
    else $error("channel transaction produced a result");

endmodule

>>> rtl/core/servo_pulse_frame_sequencer.sv
// Top level of the servo pulse frame sequencer: config registers, queues, front and back.
//
//  channel   direction  handshake                    payload
//  input     in         push / full                  i_op, i_low_bytes_*, i_high_nibbles_*
//  result    out        pop / empty                  o_slot, o_pins_high, o_period_ticks
//  config    in/out     psel, penable, pwrite/pready paddr, pwdata, prdata
//
// One item is taken per cycle while full is low; the combinational front end feeds the
// command queue. The back end retires one command per cycle, but holds a period command
// while the result queue is full; results are registered in the result queue.
// Channel items give no result; period items give one each, held in a two-entry queue.
// Reset is synchronous and restores the reset positions, slot 9 and a zero elapsed sum.
// full rises only when both queues are filled because pop stays low.
module servo_pulse_frame_sequencer
    import spfs_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_op,
    input  logic [31:0]         i_low_bytes_first,
    input  logic [15:0]         i_high_nibbles_first,
    input  logic [31:0]         i_low_bytes_second,
    input  logic [15:0]         i_high_nibbles_second,
    output logic                empty,
    input  logic                pop,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [PIN_W-1:0]    o_pins_high,
    output logic [TICK_W-1:0]   o_period_ticks,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic        r_receiver_mode;
    logic [TICK_W-1:0] r_frame_ticks;
    logic        cfg_wr;
    t_cfg        cfg;

    t_cmd        front_cmd;
    t_cmd        cmd_head;
    logic        cmd_empty;
    logic        cmd_pop;

    t_result     res_in;
    t_result     res_head;
    logic        res_push;
    logic        res_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiver_mode <= MODE_PARALLEL;
            r_frame_ticks   <= FRAME_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODE:  r_receiver_mode <= pwdata[0];
                REG_FRAME: r_frame_ticks   <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE:  prdata = {{(APB_DW-1){1'b0}}, r_receiver_mode};
            REG_FRAME: prdata = {{(APB_DW-TICK_W){1'b0}}, r_frame_ticks};
            default:   prdata = '0;
        endcase
    end

    assign cfg.mode        = r_receiver_mode;
    assign cfg.frame_ticks = r_frame_ticks;

    spfs_front u_front (
        .i_op                  (i_op),
        .i_low_bytes_first     (i_low_bytes_first),
        .i_high_nibbles_first  (i_high_nibbles_first),
        .i_low_bytes_second    (i_low_bytes_second),
        .i_high_nibbles_second (i_high_nibbles_second),
        .o_cmd                 (front_cmd)
    );

    spfs_queue #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head)
    );

    spfs_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    spfs_queue #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_head)
    );

    assign o_slot         = res_head.slot;
    assign o_pins_high    = res_head.pins;
    assign o_period_ticks = res_head.period;

endmodule
